@@ design/sndag_pkg.sv @@
// ============================================================================
// sndag_pkg - shared types and constants of the strided N-d address generator
// Register map, configuration bundle, cell-to-cell link and fixed field widths.
// ============================================================================
`default_nettype none

package sndag_pkg;

    // Fixed field widths of the register file and the item payloads
    localparam int unsigned NUM_REG_DIMS   = 3;
    localparam int unsigned NUM_DIMS_BITS  = 2;
    localparam int unsigned SIZE_BITS      = 16;
    localparam int unsigned STRIDE_BITS    = 32;
    localparam int unsigned BASE_BITS      = 32;
    localparam int unsigned PROD_BITS      = STRIDE_BITS + SIZE_BITS;
    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = 32;
    localparam int unsigned IN_DATA_BITS   = 8;
    localparam int unsigned OUT_ADDR_BITS  = 32;
    localparam int unsigned OUT_INDEX_BITS = 16;
    localparam int unsigned OUT_DATA_BITS  = OUT_ADDR_BITS + 3 * OUT_INDEX_BITS;

    // Defaults for the top-level parameters
    localparam int unsigned MAX_DIMS_DEF     = 3;
    localparam int unsigned INDEX_BITS_DEF   = 16;
    localparam int unsigned ADDRESS_BITS_DEF = 32;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_NUM_DIMS,
        REG_DIM_SIZE_0,
        REG_DIM_SIZE_1,
        REG_DIM_SIZE_2,
        REG_STRIDE_0,
        REG_STRIDE_1,
        REG_STRIDE_2,
        REG_BASE_ADDRESS
    } sndag_reg_t;

    // Configuration register bundle, dimension 0 is outermost
    typedef struct packed {
        logic [NUM_DIMS_BITS-1:0]                   num_dims;
        logic [NUM_REG_DIMS-1:0][SIZE_BITS-1:0]     dim_size;
        logic [NUM_REG_DIMS-1:0][STRIDE_BITS-1:0]   stride;
        logic [BASE_BITS-1:0]                       base_address;
    } sndag_cfg_t;

    // Control handed from an inner cell to its outer neighbor
    typedef struct packed {
        logic carry;    // all inner used cells wrap on this item
        logic at_end;   // all inner used cells sit on their last element
    } sndag_link_t;

endpackage

`default_nettype wire

@@ design/sndag_cfg.sv @@
// ============================================================================
// sndag_cfg - configuration registers
// Register file, effective dimension count and settle timer after a write.
// ============================================================================
`default_nettype none

module sndag_cfg #(
    parameter int unsigned CELLS = 3
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_write,
    input  wire logic [sndag_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [sndag_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    output sndag_pkg::sndag_cfg_t                       cfg,
    output logic [CELLS-1:0]                            used,
    output logic                                        busy
);

    localparam int unsigned SETTLE   = CELLS + 1;
    localparam int unsigned SETTLE_W = $clog2(SETTLE + 1);
    localparam int unsigned ND_W     = sndag_pkg::NUM_DIMS_BITS;
    localparam int unsigned SZ_W     = sndag_pkg::SIZE_BITS;
    localparam int unsigned ST_W     = sndag_pkg::STRIDE_BITS;
    localparam int unsigned BA_W     = sndag_pkg::BASE_BITS;

    sndag_pkg::sndag_cfg_t cfg_reg;
    sndag_pkg::sndag_cfg_t cfg_next;
    logic [SETTLE_W-1:0]   settle_reg;
    logic [SETTLE_W-1:0]   settle_next;
    logic [ND_W-1:0]       nd_raw;
    logic [ND_W-1:0]       nd_eff;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (sndag_pkg::sndag_reg_t'(cfg_index))
                sndag_pkg::REG_NUM_DIMS:     cfg_next.num_dims     = cfg_data[ND_W-1:0];
                sndag_pkg::REG_DIM_SIZE_0:   cfg_next.dim_size[0]  = cfg_data[SZ_W-1:0];
                sndag_pkg::REG_DIM_SIZE_1:   cfg_next.dim_size[1]  = cfg_data[SZ_W-1:0];
                sndag_pkg::REG_DIM_SIZE_2:   cfg_next.dim_size[2]  = cfg_data[SZ_W-1:0];
                sndag_pkg::REG_STRIDE_0:     cfg_next.stride[0]    = cfg_data[ST_W-1:0];
                sndag_pkg::REG_STRIDE_1:     cfg_next.stride[1]    = cfg_data[ST_W-1:0];
                sndag_pkg::REG_STRIDE_2:     cfg_next.stride[2]    = cfg_data[ST_W-1:0];
                sndag_pkg::REG_BASE_ADDRESS: cfg_next.base_address = cfg_data[BA_W-1:0];
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    // Settle timer: cells rebuild their precomputed sums after any write
    always_comb
    begin
        if (cfg_write)
            settle_next = SETTLE_W'(SETTLE);
        else if (settle_reg != '0)
            settle_next = settle_reg - SETTLE_W'(1);
        else
            settle_next = settle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_dims     <= ND_W'(1);
            cfg_reg.dim_size[0]  <= SZ_W'(1);
            cfg_reg.dim_size[1]  <= SZ_W'(1);
            cfg_reg.dim_size[2]  <= SZ_W'(1);
            cfg_reg.stride       <= '0;
            cfg_reg.base_address <= '0;
            settle_reg           <= '0;
        end
        else
        begin
            cfg_reg    <= cfg_next;
            settle_reg <= settle_next;
        end
    end

    // Dimensions in use: zero counts as one, clipped to the cell count
    assign nd_raw = (cfg_reg.num_dims == '0) ? ND_W'(1) : cfg_reg.num_dims;
    assign nd_eff = (32'(nd_raw) > CELLS) ? ND_W'(CELLS) : nd_raw;

    for (genvar k = 0; k < CELLS; k++)
    begin : g_used
        assign used[k] = (k < int'(nd_eff));
    end

    assign cfg  = cfg_reg;
    assign busy = (settle_reg != '0);

endmodule

`default_nettype wire

@@ design/sndag_cell.sv @@
// ============================================================================
// sndag_cell - one dimension of the odometer
// Holds the position counter and the precomputed offset steps of a dimension,
// takes carry, end flag and offset step from its inner neighbor.
// ============================================================================
`default_nettype none

module sndag_cell #(
    parameter int unsigned INDEX_BITS   = 16,
    parameter int unsigned ADDRESS_BITS = 32
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                used,
    input  wire logic                                advance,
    input  wire logic                                restart,
    input  wire logic [sndag_pkg::SIZE_BITS-1:0]     size,
    input  wire logic [sndag_pkg::STRIDE_BITS-1:0]   stride,
    input  sndag_pkg::sndag_link_t                   link_in,
    output sndag_pkg::sndag_link_t                   link_out,
    input  wire logic [ADDRESS_BITS-1:0]             delta_in,
    output logic [ADDRESS_BITS-1:0]                  delta_out,
    input  wire logic [ADDRESS_BITS-1:0]             suffix_in,
    output logic [ADDRESS_BITS-1:0]                  suffix_out,
    output logic [INDEX_BITS-1:0]                    index
);

    localparam int unsigned SZ_W  = sndag_pkg::SIZE_BITS;
    localparam int unsigned PR_W  = sndag_pkg::PROD_BITS;
    localparam int unsigned CMP_W = (INDEX_BITS > SZ_W) ? INDEX_BITS : SZ_W;

    logic [INDEX_BITS-1:0]   cnt_reg;
    logic [INDEX_BITS-1:0]   cnt_next;
    logic [ADDRESS_BITS-1:0] adj_reg;     // stride - stride * size
    logic [ADDRESS_BITS-1:0] adj_next;
    logic [ADDRESS_BITS-1:0] suffix_reg;  // sum of adj over this and inner used cells
    logic [ADDRESS_BITS-1:0] suffix_next;
    logic [ADDRESS_BITS-1:0] d_reg;       // step when this cell is the one that stops
    logic [ADDRESS_BITS-1:0] d_next;

    logic [SZ_W-1:0]         size_eff;
    logic [INDEX_BITS-1:0]   cur;
    logic [INDEX_BITS-1:0]   inc;
    logic                    wrap;
    logic                    at_end;
    logic                    step;
    logic [PR_W-1:0]         prod;

    // Current position, wrap and end tests
    assign size_eff = (size == '0) ? SZ_W'(1) : size;
    assign cur      = restart ? '0 : cnt_reg;
    assign inc      = cur + INDEX_BITS'(1);
    assign wrap     = (CMP_W'(inc) >= CMP_W'(size_eff));
    assign at_end   = (CMP_W'(cur) >= CMP_W'(size_eff - SZ_W'(1)));
    assign step     = used & link_in.carry;

    // Hand-off to the outer neighbor; unused cells pass through
    assign link_out.carry  = used ? (link_in.carry & wrap) : link_in.carry;
    assign link_out.at_end = used ? (link_in.at_end & at_end) : link_in.at_end;
    assign delta_out       = (step & !wrap) ? d_reg : delta_in;
    assign index           = used ? cur : '0;
    assign suffix_out      = suffix_reg;

    // Counter update
    always_comb
    begin
        cnt_next = cnt_reg;
        if (advance)
        begin
            if (step)
                cnt_next = wrap ? '0 : inc;
            else
                cnt_next = cur;
        end
    end

    // Offset steps derived from configuration, rebuilt every cycle
    assign prod        = PR_W'(stride) * PR_W'(size_eff);
    assign adj_next    = ADDRESS_BITS'(stride) - ADDRESS_BITS'(prod);
    assign suffix_next = (used ? adj_reg : '0) + suffix_in;
    assign d_next      = ADDRESS_BITS'(stride) + suffix_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            adj_reg    <= '0;
            suffix_reg <= '0;
            d_reg      <= '0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            adj_reg    <= adj_next;
            suffix_reg <= suffix_next;
            d_reg      <= d_next;
        end
    end

endmodule

`default_nettype wire

@@ design/strided_nd_address_generator_unit.sv @@
// ============================================================================
// strided_nd_address_generator_unit - strided N-d address generator
// Walks a strided array of up to three dimensions in row-major order.
// ============================================================================
// Usage:
//   Each item on s_axis (bit 0 of tdata: restart) asks for one element. The
//   answer on m_axis carries the element's byte address, its outer, middle
//   and inner indices and tlast on the final element of the walk; the walk
//   then wraps to the first element. restart = 1 answers with the first
//   element and continues from there.
//   m_axis_tvalid rises in the cycle after acceptance; one item is taken
//   every cycle while s_axis_tready is high. The odometer is a row of
//   cells, one per dimension, with the carry rippling from inner to outer
//   cell; the offset adds one precomputed step per item.
//   After a configuration write s_axis_tready stays low while the settle
//   timer runs down and the cells rebuild their precomputed steps.
//   Configuration is written while no item is in flight.
//   Reset clears the position and offset and loads the register defaults
//   (one dimension of size one, zero strides, zero base).
//   While m_axis is stalled the result is held in the output register and
//   s_axis_tready follows m_axis_tready.
// ============================================================================
`default_nettype none

module strided_nd_address_generator_unit #(
    parameter int unsigned MAX_DIMS     = sndag_pkg::MAX_DIMS_DEF,
    parameter int unsigned INDEX_BITS   = sndag_pkg::INDEX_BITS_DEF,
    parameter int unsigned ADDRESS_BITS = sndag_pkg::ADDRESS_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // config port
    input  wire logic                                   cfg_write,
    input  wire logic [sndag_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [sndag_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // requests
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    input  wire logic [sndag_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,  // restart
    // results
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // element_address, index_outer, index_middle, index_inner
    output logic [sndag_pkg::OUT_DATA_BITS-1:0]         m_axis_tdata,
    output logic                                        m_axis_tlast
);

    localparam int unsigned NRD   = sndag_pkg::NUM_REG_DIMS;
    localparam int unsigned CELLS = (MAX_DIMS < NRD) ? MAX_DIMS : NRD;
    localparam int unsigned OA_W  = sndag_pkg::OUT_ADDR_BITS;
    localparam int unsigned OI_W  = sndag_pkg::OUT_INDEX_BITS;

    sndag_pkg::sndag_cfg_t                  cfg;
    logic [CELLS-1:0]                       used;
    logic                                   busy;

    logic                                   accept;
    logic                                   restart;
    logic [ADDRESS_BITS-1:0]                cur_offset;

    sndag_pkg::sndag_link_t [CELLS:0]       link;
    logic [CELLS:0][ADDRESS_BITS-1:0]       delta;
    logic [CELLS:0][ADDRESS_BITS-1:0]       suffix;
    logic [CELLS-1:0][INDEX_BITS-1:0]       cell_index;
    logic [NRD-1:0][OI_W-1:0]               index_field;

    logic [ADDRESS_BITS-1:0]                offset_reg;
    logic [ADDRESS_BITS-1:0]                offset_next;
    logic [ADDRESS_BITS-1:0]                addr_sum;
    logic                                   out_valid_reg;
    logic [OA_W-1:0]                        out_addr_reg;
    logic [NRD-1:0][OI_W-1:0]               out_index_reg;
    logic                                   out_last_reg;

    // Configuration registers
    sndag_cfg #(
        .CELLS (CELLS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .used      (used),
        .busy      (busy)
    );

    // Handshake
    assign s_axis_tready = !busy && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign restart       = s_axis_tdata[0];

    // Chain boundary at the innermost cell
    assign link[CELLS].carry  = 1'b1;
    assign link[CELLS].at_end = 1'b1;
    assign suffix[CELLS]      = '0;
    assign delta[CELLS]       = suffix[0];  // step when every used dimension wraps

    // Row of cells, cell 0 outermost
    for (genvar k = 0; k < CELLS; k++)
    begin : g_cell
        sndag_cell #(
            .INDEX_BITS   (INDEX_BITS),
            .ADDRESS_BITS (ADDRESS_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .used       (used[k]),
            .advance    (accept),
            .restart    (restart),
            .size       (cfg.dim_size[k]),
            .stride     (cfg.stride[k]),
            .link_in    (link[k+1]),
            .link_out   (link[k]),
            .delta_in   (delta[k+1]),
            .delta_out  (delta[k]),
            .suffix_in  (suffix[k+1]),
            .suffix_out (suffix[k]),
            .index      (cell_index[k])
        );
    end

    // Map cells onto the three index fields
    for (genvar k = 0; k < NRD; k++)
    begin : g_field
        if (k < CELLS)
        begin : g_live
            assign index_field[k] = OI_W'(cell_index[k]);
        end
        else
        begin : g_none
            assign index_field[k] = '0;
        end
    end

    // Running offset and element address
    assign cur_offset  = restart ? '0 : offset_reg;
    assign addr_sum    = ADDRESS_BITS'(cfg.base_address) + cur_offset;
    assign offset_next = accept ? (cur_offset + delta[0]) : offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_addr_reg  <= OA_W'(addr_sum);
            out_index_reg <= index_field;
            out_last_reg  <= link[0].at_end;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_index_reg[2], out_index_reg[1], out_index_reg[0], out_addr_reg};
    assign m_axis_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ design/sndag_checker.sv @@
// ============================================================================
// sndag_checker - port-level checks of the address generator
// Watches the top-level ports only; attached by bind.
// ============================================================================
`default_nettype none

module sndag_checker (
    input wire logic                                   clk,
    input wire logic                                   rst_n,
    input wire logic                                   cfg_write,
    input wire logic                                   s_axis_tvalid,
    input wire logic                                   s_axis_tready,
    input wire logic [sndag_pkg::IN_DATA_BITS-1:0]     s_axis_tdata,
    input wire logic                                   m_axis_tvalid,
    input wire logic                                   m_axis_tready,
    input wire logic [sndag_pkg::OUT_DATA_BITS-1:0]    m_axis_tdata
);

    // Steps are rebuilt after a write: no item is taken in the next cycle
    a_settle_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> !s_axis_tready)
        else $error("item taken right after a configuration write");

    // Every accepted item shows up on the output in the next cycle
    a_one_cycle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("accepted item has no result");

    // A restart answers with the first element: all indices zero
    a_restart_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[0])
        |=> (m_axis_tdata[sndag_pkg::OUT_DATA_BITS-1:sndag_pkg::OUT_ADDR_BITS] == '0))
        else $error("restart result does not point at the first element");

    // A stalled result blocks new items
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("item taken while the output register is stalled");

    // Handshake rule: a pending result stays valid
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped while stalled");

endmodule

bind strided_nd_address_generator_unit sndag_checker u_sndag_checker (.*);

`default_nettype wire
